@@ hw/rtl/gsa_pkg.sv @@
// Shared constants, codes and item types of the generational slot allocator.
package gsa_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int GEN_W  = 16;
    localparam int STAT_W = 2;
    localparam int LIVE_W = 7;
    localparam int LOW_W  = 6;
    localparam int HW_W   = 7;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SLOT_W-1:0] slot_index;
        logic [GEN_W-1:0]  handle_generation;
    } gsa_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] granted_slot;
        logic [GEN_W-1:0]  granted_generation;
        logic [LIVE_W-1:0] live_count;
        logic [LOW_W-1:0]  lowest_live;
        logic [HW_W-1:0]   high_water;
    } gsa_out_t;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] generation;
    } slot_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        slot_entry_t       wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

@@ hw/rtl/generational_slot_allocator.sv @@
// Top level of the generational slot allocator: sequencer, slot table and output register.
// Each input item on s_* allocates a slot, releases a handle or checks a handle;
// each item yields exactly one result item on m_*, in order. Both channels use
// valid/ready and move an item when both are high.
// The slot table holds an alive bit and a 16-bit generation per slot in one RAM
// with a single read and a single write port.
// Steps per item: a full pool or an unused operation goes straight to its result;
// a check or a rejected release reads its slot first; an allocate reads and writes
// its slot and then scans forward for the next free slot; an accepted release writes
// its slot, then runs the lowest-live scan if it freed the lowest live slot and the
// high-water scan if it freed the top one. A scan probes one slot per cycle.
// One item is processed at a time; the next item is accepted in the cycle after
// the result enters the output register, even while that result waits.
// After reset the block clears all SLOTS (64) entries of the slot table with
// s_ready low. If m_ready is held low, one finished result waits in the output
// register and a second finished result waits in the sequencer, which then
// stops accepting items.
module generational_slot_allocator
    import gsa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gsa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gsa_out_t m_data
);

    ram_req_t    ram_req;
    slot_entry_t rd_data;
    logic        res_valid;
    logic        res_free;
    gsa_out_t    res_data;
    logic        m_valid_reg, m_valid_next;
    gsa_out_t    m_data_reg, m_data_next;

    gsa_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    gsa_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/gsa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/gsa_seq.sv @@
// Sequencer that reads, updates and scans the slot table for each item.
module gsa_seq
    import gsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gsa_in_t     s_data,
    input  logic        res_free,
    output logic        res_valid,
    output gsa_out_t    res_data,
    output ram_req_t    ram_req,
    input  slot_entry_t rd_data
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_FF   = 3'd3;
    localparam logic [2:0] S_LL   = 3'd4;
    localparam logic [2:0] S_HWS  = 3'd5;
    localparam logic [2:0] S_HW   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  probe_reg, probe_next;
    logic [CNT_W-1:0]  first_free_reg, first_free_next;
    logic [IDX_W-1:0]  lowest_reg, lowest_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [CNT_W-1:0]  alive_total_reg, alive_total_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic              idx_ok_reg, idx_ok_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]  gslot_reg, gslot_next;
    logic [GEN_W-1:0]  ggen_reg, ggen_next;

    always_comb begin
        logic [CNT_W-1:0] idx_ext;
        logic [CNT_W-1:0] idx_inc;
        logic [CNT_W-1:0] probe_inc;
        logic [GEN_W-1:0] gen_inc;
        logic             handle_ok;

        idx_ext   = CNT_W'(idx_reg);
        idx_inc   = idx_ext + CNT_W'(1);
        probe_inc = probe_reg + CNT_W'(1);
        gen_inc   = rd_data.generation + GEN_W'(1);
        handle_ok = idx_ok_reg && rd_data.alive && (rd_data.generation == gen_reg);

        state_next       = state_reg;
        probe_next       = probe_reg;
        first_free_next  = first_free_reg;
        lowest_next      = lowest_reg;
        hw_next          = hw_reg;
        alive_total_next = alive_total_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        gen_next         = gen_reg;
        idx_ok_next      = idx_ok_reg;
        status_next      = status_reg;
        gslot_next       = gslot_reg;
        ggen_next        = ggen_reg;
        ram_req          = '0;
        s_ready          = 1'b0;
        res_valid        = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = probe_reg[IDX_W-1:0];
                if (probe_reg[IDX_W-1:0] == LAST_IDX) begin
                    probe_next = '0;
                    state_next = S_IDLE;
                end else begin
                    probe_next = probe_inc;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = s_data.operation;
                    gen_next    = s_data.handle_generation;
                    idx_ok_next = (32'(s_data.slot_index) < SLOTS);
                    gslot_next  = '0;
                    ggen_next   = '0;
                    unique case (s_data.operation)
                        OP_ALLOC: begin
                            if (first_free_reg == SLOTS_CNT) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                idx_next        = first_free_reg[IDX_W-1:0];
                                ram_req.rd_addr = first_free_reg[IDX_W-1:0];
                                state_next      = S_CHK;
                            end
                        end
                        OP_RELEASE, OP_CHECK: begin
                            idx_next        = IDX_W'(s_data.slot_index);
                            ram_req.rd_addr = IDX_W'(s_data.slot_index);
                            state_next      = S_CHK;
                        end
                        default: begin
                            status_next = ST_BAD;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_CHK: begin
                unique case (op_reg)
                    OP_ALLOC: begin
                        ram_req.wr_en              = 1'b1;
                        ram_req.wr_addr            = idx_reg;
                        ram_req.wr_data.alive      = 1'b1;
                        ram_req.wr_data.generation = gen_inc;
                        status_next      = ST_OK;
                        gslot_next       = idx_reg;
                        ggen_next        = gen_inc;
                        alive_total_next = alive_total_reg + CNT_W'(1);
                        if (idx_reg < lowest_reg) begin
                            lowest_next = idx_reg;
                        end
                        if (idx_inc == SLOTS_CNT) begin
                            first_free_next = SLOTS_CNT;
                            if (SLOTS_CNT > hw_reg) begin
                                hw_next = SLOTS_CNT;
                            end
                            state_next = S_DONE;
                        end else begin
                            ram_req.rd_addr = idx_inc[IDX_W-1:0];
                            probe_next      = idx_inc;
                            state_next      = S_FF;
                        end
                    end
                    OP_RELEASE: begin
                        if (!handle_ok) begin
                            status_next = ST_BAD;
                            state_next  = S_DONE;
                        end else begin
                            ram_req.wr_en              = 1'b1;
                            ram_req.wr_addr            = idx_reg;
                            ram_req.wr_data.alive      = 1'b0;
                            ram_req.wr_data.generation = rd_data.generation;
                            status_next = ST_OK;
                            if (idx_ext < first_free_reg) begin
                                first_free_next = idx_ext;
                            end
                            if (alive_total_reg != '0) begin
                                alive_total_next = alive_total_reg - CNT_W'(1);
                            end
                            if (idx_reg == lowest_reg) begin
                                if (idx_inc == SLOTS_CNT) begin
                                    lowest_next = '0;
                                    state_next  = S_HWS;
                                end else begin
                                    ram_req.rd_addr = idx_inc[IDX_W-1:0];
                                    probe_next      = idx_inc;
                                    state_next      = S_LL;
                                end
                            end else begin
                                state_next = S_HWS;
                            end
                        end
                    end
                    default: begin
                        status_next = handle_ok ? ST_OK : ST_BAD;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_FF: begin
                if (!rd_data.alive) begin
                    first_free_next = probe_reg;
                    if (probe_reg > hw_reg) begin
                        hw_next = probe_reg;
                    end
                    state_next = S_DONE;
                end else if (probe_inc == SLOTS_CNT) begin
                    first_free_next = SLOTS_CNT;
                    if (SLOTS_CNT > hw_reg) begin
                        hw_next = SLOTS_CNT;
                    end
                    state_next = S_DONE;
                end else begin
                    ram_req.rd_addr = probe_inc[IDX_W-1:0];
                    probe_next      = probe_inc;
                end
            end
            S_LL: begin
                if (rd_data.alive) begin
                    lowest_next = probe_reg[IDX_W-1:0];
                    state_next  = S_HWS;
                end else if (probe_inc == SLOTS_CNT) begin
                    lowest_next = '0;
                    state_next  = S_HWS;
                end else begin
                    ram_req.rd_addr = probe_inc[IDX_W-1:0];
                    probe_next      = probe_inc;
                end
            end
            S_HWS: begin
                if ((hw_reg != '0) && (idx_ext == hw_reg - CNT_W'(1))) begin
                    hw_next = idx_ext;
                    if (idx_ext == '0) begin
                        state_next = S_DONE;
                    end else begin
                        ram_req.rd_addr = idx_reg - IDX_W'(1);
                        probe_next      = idx_ext - CNT_W'(1);
                        state_next      = S_HW;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_HW: begin
                if (rd_data.alive) begin
                    hw_next    = probe_inc;
                    state_next = S_DONE;
                end else if (probe_reg == '0) begin
                    hw_next    = '0;
                    state_next = S_DONE;
                end else begin
                    hw_next         = probe_reg;
                    ram_req.rd_addr = probe_reg[IDX_W-1:0] - IDX_W'(1);
                    probe_next      = probe_reg - CNT_W'(1);
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res_data.status             = status_reg;
        res_data.granted_slot       = SLOT_W'(gslot_reg);
        res_data.granted_generation = ggen_reg;
        res_data.live_count         = LIVE_W'(alive_total_reg);
        res_data.lowest_live        = LOW_W'(lowest_reg);
        res_data.high_water         = HW_W'(hw_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLR;
            probe_reg       <= '0;
            first_free_reg  <= '0;
            lowest_reg      <= '0;
            hw_reg          <= '0;
            alive_total_reg <= '0;
        end else begin
            state_reg       <= state_next;
            probe_reg       <= probe_next;
            first_free_reg  <= first_free_next;
            lowest_reg      <= lowest_next;
            hw_reg          <= hw_next;
            alive_total_reg <= alive_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        gen_reg    <= gen_next;
        idx_ok_reg <= idx_ok_next;
        status_reg <= status_next;
        gslot_reg  <= gslot_next;
        ggen_reg   <= ggen_next;
    end

`ifndef SYNTH
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Sequencer took a second item while one was in flight.");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> (state_reg == S_CLR || state_reg == S_CHK))
        else $error("Slot table written outside the clear pass or update step.");

    a_counts_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alive_total_reg <= SLOTS_CNT && first_free_reg <= SLOTS_CNT && hw_reg <= SLOTS_CNT)
        else $error("Pool counters exceed the slot count.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !res_free |=> state_reg == S_DONE && $stable(res_data))
        else $error("Finished result changed while waiting for the output register.");
`endif

endmodule
